// ===== rtl/scba_pkg.sv =====
// ----------------------------------------------------------------------------
// scba_pkg: size-class block allocator definitions
// Pool geometry, operation and status codes, and the item types of both
// channels.
// ----------------------------------------------------------------------------
package scba_pkg;

  localparam int unsigned POOL_COUNT         = 3;
  localparam int unsigned SMALL_POOL_BLOCKS  = 8;
  localparam int unsigned MEDIUM_POOL_BLOCKS = 8;
  localparam int unsigned LARGE_POOL_BLOCKS  = 4;
  localparam int unsigned HEADER_BYTES       = 8;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SIZE_W = 16;

  // blocks in pool k
  function automatic int unsigned pool_blocks(input int unsigned k);
    case (k)
      0:       return SMALL_POOL_BLOCKS;
      1:       return MEDIUM_POOL_BLOCKS;
      default: return LARGE_POOL_BLOCKS;
    endcase
  endfunction

  // log2 of the block size of pool k (16, 32, 64 bytes)
  function automatic int unsigned blk_shift(input int unsigned k);
    case (k)
      0:       return 4;
      1:       return 5;
      default: return 6;
    endcase
  endfunction

  function automatic int unsigned blk_bytes(input int unsigned k);
    return 32'd1 << blk_shift(k);
  endfunction

  // byte offset of pool k's first block from the area base
  function automatic int unsigned pool_offset(input int unsigned k);
    int unsigned off;
    off = 0;
    for (int unsigned j = 0; j < k; j++) begin
      off += pool_blocks(j) * blk_bytes(j);
    end
    return off;
  endfunction

  function automatic int unsigned max_blocks();
    int unsigned m;
    m = 0;
    for (int unsigned j = 0; j < POOL_COUNT; j++) begin
      if (pool_blocks(j) > m) begin
        m = pool_blocks(j);
      end
    end
    return m;
  endfunction

  localparam int unsigned MAX_BLOCKS = max_blocks();
  localparam int unsigned IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_NO_FIT   = 2'd2,
    STATUS_BAD_FREE = 2'd3
  } status_t;

  typedef struct packed {
    func_t                    func;
    logic signed [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0]        block_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    status_t           status;
  } out_item_t;

endpackage

// ===== rtl/size_class_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// size_class_block_allocator_unit: fixed-size block pool allocator
// Three pools of 16-, 32- and 64-byte blocks with LIFO free stacks.
// ----------------------------------------------------------------------------
// Each item is an allocate or a free request and produces exactly one result
// item. An accepted item sits in an input register, the pool lookup, stack
// pop/push and address math happen in a single combinational pass, and the
// result lands in the output register at the edge on which the item
// advances: out_valid rises at that edge, so each result passes the input
// register and then the output register before its handshake, and one
// item per cycle is sustained as long as the result side does not stall. The
// free stacks, counts and in-use bits are flip-flops, so a pop or push of one
// pool completes in the same edge that registers the result; the next item
// sees the updated state. Allocate picks the first pool whose block minus the
// 8-byte header holds req_size and never falls back to a larger pool when that
// one is empty. Free decodes the pool from the offset to area_base and rejects
// misaligned, out-of-range or already-free addresses without touching state.
// area_base is written through cfg_wr_en/cfg_wr_data and should only change
// while no item is in flight.
// ----------------------------------------------------------------------------
module size_class_block_allocator_unit
  import scba_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [ADDR_W-1:0]   cfg_wr_data
);

  // Configuration
  logic [ADDR_W-1:0] area_base;

  // Input register
  logic     in_q_valid;
  in_item_t in_q;

  // Pool state
  logic [IDX_W-1:0]      stack  [POOL_COUNT][MAX_BLOCKS];
  logic [CNT_W-1:0]      count  [POOL_COUNT];
  logic [MAX_BLOCKS-1:0] in_use [POOL_COUNT];

  // Datapath
  logic                  adv;
  logic [ADDR_W-1:0]     free_off;
  logic [POOL_COUNT-1:0] fits;
  logic [POOL_COUNT-1:0] alloc_sel;
  logic [POOL_COUNT-1:0] do_pop;
  logic [POOL_COUNT-1:0] do_push;
  logic [POOL_COUNT-1:0] count_ok;
  logic [IDX_W-1:0]      top_idx  [POOL_COUNT];
  logic [IDX_W-1:0]      rel_idx  [POOL_COUNT];
  logic [ADDR_W-1:0]     alloc_addr [POOL_COUNT];
  out_item_t             result;

  // Item moves from the input register to the output register when the
  // output is empty or being drained this cycle.
  assign adv      = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !adv;

  assign free_off = in_q.block_address - ADDR_W'(HEADER_BYTES) - area_base;

  always_comb begin
    logic                  taken;
    logic [CNT_W-1:0]      cnt_dec;
    logic [ADDR_W-1:0]     rel;
    logic                  in_range;
    logic                  aligned;
    logic [POOL_COUNT-1:0] free_ok;
    taken    = 1'b0;
    cnt_dec  = '0;
    rel      = '0;
    in_range = 1'b0;
    aligned  = 1'b0;
    free_ok  = '0;
    for (int unsigned k = 0; k < POOL_COUNT; k++) begin
      // allocate: size fit, negative sizes never fit
      fits[k] = !in_q.req_size[SIZE_W-1] &&
                ($unsigned(in_q.req_size) <= SIZE_W'(blk_bytes(k) - HEADER_BYTES));
      alloc_sel[k] = fits[k] && !taken;
      taken        = taken | fits[k];

      cnt_dec       = count[k] - CNT_W'(1);
      top_idx[k]    = stack[k][cnt_dec[IDX_W-1:0]];
      alloc_addr[k] = area_base + ADDR_W'(pool_offset(k)) +
                      (ADDR_W'(top_idx[k]) << blk_shift(k)) + ADDR_W'(HEADER_BYTES);

      // free: range and alignment decode
      rel        = free_off - ADDR_W'(pool_offset(k));
      in_range   = (free_off >= ADDR_W'(pool_offset(k))) &&
                   (rel < ADDR_W'(pool_blocks(k) * blk_bytes(k)));
      aligned    = (rel & ADDR_W'(blk_bytes(k) - 1)) == '0;
      rel_idx[k] = IDX_W'(rel >> blk_shift(k));
      free_ok[k] = in_range && aligned && in_use[k][rel_idx[k]] &&
                   (count[k] < CNT_W'(pool_blocks(k)));

      do_pop[k]   = (in_q.func == FUNC_ALLOC) && alloc_sel[k] && (count[k] != '0);
      do_push[k]  = (in_q.func == FUNC_FREE) && free_ok[k];
      count_ok[k] = count[k] <= CNT_W'(pool_blocks(k));
    end

    result.result_address = '0;
    if (in_q.func == FUNC_ALLOC) begin
      result.status = STATUS_NO_FIT;
      for (int unsigned k = 0; k < POOL_COUNT; k++) begin
        if (alloc_sel[k]) begin
          if (count[k] == '0) begin
            result.status = STATUS_EMPTY;
          end else begin
            result.status         = STATUS_OK;
            result.result_address = alloc_addr[k];
          end
        end
      end
    end else begin
      result.status = (|free_ok) ? STATUS_OK : STATUS_BAD_FREE;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      area_base <= '0;
    end else if (cfg_wr_en) begin
      area_base <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (adv) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  // Free stacks, counts and in-use bits; reset puts index 0 on top.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int unsigned k = 0; k < POOL_COUNT; k++) begin
        count[k]  <= CNT_W'(pool_blocks(k));
        in_use[k] <= '0;
        for (int unsigned i = 0; i < MAX_BLOCKS; i++) begin
          if (i < pool_blocks(k)) begin
            stack[k][i] <= IDX_W'(pool_blocks(k) - 1 - i);
          end else begin
            stack[k][i] <= '0;
          end
        end
      end
    end else if (adv) begin
      for (int unsigned k = 0; k < POOL_COUNT; k++) begin
        if (do_pop[k]) begin
          count[k]                 <= count[k] - CNT_W'(1);
          in_use[k][top_idx[k]]    <= 1'b1;
        end else if (do_push[k]) begin
          stack[k][count[k][IDX_W-1:0]] <= rel_idx[k];
          count[k]                      <= count[k] + CNT_W'(1);
          in_use[k][rel_idx[k]]         <= 1'b0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= result;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // free counts never run past the pool size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    &count_ok)
    else $error("free count exceeds pool size");

  // only a successful allocate returns a nonzero address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != STATUS_OK || $past(in_q.func) == FUNC_FREE)
      && $past(adv) |-> out_data.result_address == '0)
    else $error("nonzero address on failed allocate or free");

  // input side only backs up behind a stalled full output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule
